// File: design/itp_pkg.sv
package itp_pkg;

  localparam int unsigned DEFAULT_MAX_TEXT = 4095;
  localparam int unsigned COUNT_LIMIT =
    (DEFAULT_MAX_TEXT < 4095) ? DEFAULT_MAX_TEXT : 4095;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [5:0] RADIX_RESET = 6'd10;
  localparam logic [5:0] RADIX_DETECT = 6'd0;
  localparam logic [5:0] BASE_OCT = 6'd8;
  localparam logic [5:0] BASE_DEC = 6'd10;
  localparam logic [5:0] BASE_HEX = 6'd16;

  // Worth of a byte that is neither digit nor letter; above every base.
  localparam logic [6:0] WORTH_NONE = 7'd64;

  typedef struct packed {
    logic       start_req;
    logic [7:0] character;
  } in_t;

  typedef struct packed {
    logic signed [63:0] value;
    logic [11:0]        consumed;
  } out_t;

  // Byte classification handed from the front to the back.
  typedef struct packed {
    logic       start;
    logic       is_space;
    logic       is_minus;
    logic       is_plus;
    logic       is_zero;
    logic       is_x;
    logic [6:0] worth;
  } cls_t;

  typedef enum logic [2:0] {
    PH_SPACE,
    PH_PREFIX,
    PH_ZERO,
    PH_DIGITS,
    PH_DONE
  } phase_t;

endpackage

// File: design/itp_front.sv
module itp_front
  import itp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic cls_valid,
  input  logic cls_ready,
  output cls_t cls_data
);

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;

  logic       valid_r, valid_nxt;
  cls_t       data_r;
  cls_t       cls_nxt;
  logic [7:0] c;
  logic       take;

  assign c        = in_data.character;
  assign in_ready = !valid_r || cls_ready;
  assign take     = in_valid && in_ready;

  always_comb begin
    cls_nxt.start    = in_data.start_req;
    cls_nxt.is_space = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    cls_nxt.is_minus = (c == CH_MINUS);
    cls_nxt.is_plus  = (c == CH_PLUS);
    cls_nxt.is_zero  = (c == CH_ZERO);
    cls_nxt.is_x     = (c == CH_LX) || (c == CH_UX);
    priority if (c >= CH_ZERO && c <= CH_NINE) begin
      cls_nxt.worth = 7'(c - CH_ZERO);
    end else if (c >= CH_LA && c <= CH_LZ) begin
      cls_nxt.worth = 7'(c - CH_LA + 8'd10);
    end else if (c >= CH_UA && c <= CH_UZ) begin
      cls_nxt.worth = 7'(c - CH_UA + 8'd10);
    end else begin
      cls_nxt.worth = WORTH_NONE;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (cls_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data_r <= cls_nxt;
    end
  end

  assign cls_valid = valid_r;
  assign cls_data  = data_r;

endmodule

// File: design/itp_queue.sv
module itp_queue
  import itp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_ready,
  input  cls_t wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output cls_t rd_data
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_C = PTR_W'(QUEUE_DEPTH - 1);

  cls_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push, pop;

  assign wr_ready = (count_r != DEPTH_C);
  assign rd_valid = (count_r != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_C) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_C) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// File: design/itp_back.sv
module itp_back
  import itp_pkg::*;
#(
  parameter int unsigned MAX_TEXT = DEFAULT_MAX_TEXT
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [5:0] radix,
  input  logic       cls_valid,
  output logic       cls_ready,
  input  cls_t       cls_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_t       out_data
);

  localparam logic [11:0] LIMIT_C = 12'((MAX_TEXT < 4095) ? MAX_TEXT : 4095);

  phase_t      phase_r, phase_nxt, ph_e;
  logic [63:0] acc_r, acc_nxt, acc_e;
  logic        neg_r, neg_nxt, neg_e;
  logic [5:0]  base_r, base_nxt, base_e;
  logic [11:0] cnt_r, cnt_nxt, cnt_e;
  logic        out_valid_r, out_valid_nxt;
  out_t        out_data_r;

  logic        pop, emit;
  logic [11:0] cnt_take;
  logic [5:0]  base_dig;
  logic        stop_dig;
  logic [63:0] prod;
  logic        first;

  assign cls_ready = !out_valid_r || out_ready;
  assign pop       = cls_valid && cls_ready;

  // A start request clears parse state before this byte is handled.
  assign ph_e   = cls_data.start ? PH_SPACE : phase_r;
  assign acc_e  = cls_data.start ? '0 : acc_r;
  assign neg_e  = cls_data.start ? 1'b0 : neg_r;
  assign base_e = cls_data.start ? '0 : base_r;
  assign cnt_e  = cls_data.start ? '0 : cnt_r;

  assign cnt_take = (cnt_e < LIMIT_C) ? cnt_e + 12'd1 : cnt_e;
  assign first    = (ph_e == PH_SPACE) || (ph_e == PH_PREFIX);
  assign base_dig = first ? ((radix == RADIX_DETECT) ? BASE_DEC : radix) : base_e;
  assign stop_dig = ({1'b0, base_dig} <= cls_data.worth);
  assign prod     = acc_e * 64'(base_dig);

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    base_nxt  = base_r;
    cnt_nxt   = cnt_r;
    emit      = 1'b0;
    if (pop) begin
      phase_nxt = ph_e;
      acc_nxt   = acc_e;
      neg_nxt   = neg_e;
      base_nxt  = base_e;
      cnt_nxt   = cnt_e;
      unique case (ph_e)
        PH_SPACE, PH_PREFIX, PH_ZERO, PH_DIGITS: begin
          priority if (ph_e == PH_SPACE && cls_data.is_space) begin
            cnt_nxt = cnt_take;
          end else if (ph_e == PH_SPACE && (cls_data.is_minus || cls_data.is_plus)) begin
            neg_nxt   = cls_data.is_minus;
            cnt_nxt   = cnt_take;
            phase_nxt = PH_PREFIX;
          end else if (first && radix == RADIX_DETECT && cls_data.is_zero) begin
            base_nxt  = BASE_OCT;
            cnt_nxt   = cnt_take;
            phase_nxt = PH_ZERO;
          end else if (first && radix == BASE_HEX && cls_data.is_zero) begin
            base_nxt  = base_dig;
            cnt_nxt   = cnt_take;
            phase_nxt = PH_ZERO;
          end else if (ph_e == PH_ZERO && cls_data.is_x) begin
            base_nxt  = BASE_HEX;
            cnt_nxt   = cnt_take;
            phase_nxt = PH_DIGITS;
          end else begin
            base_nxt = base_dig;
            if (stop_dig) begin
              emit      = 1'b1;
              phase_nxt = PH_DONE;
            end else begin
              acc_nxt   = prod + 64'(cls_data.worth);
              cnt_nxt   = cnt_take;
              phase_nxt = PH_DIGITS;
            end
          end
        end
        default: begin
          // Parse ended: drop bytes until the next start request.
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SPACE;
      acc_r       <= '0;
      neg_r       <= 1'b0;
      base_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      acc_r       <= acc_nxt;
      neg_r       <= neg_nxt;
      base_r      <= base_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r.value    <= neg_e ? (64'd0 - acc_e) : acc_e;
      out_data_r.consumed <= cnt_e;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: design/integer_text_parser.sv
// Integer text parser: reads text one byte per transaction and returns the
// integer it spells, in the manner of strtol.
// Input channel (in_valid/in_ready/in_data): start_req set on the first byte
// of a new string clears the parse; character carries the byte, 0 ends text.
// Leading whitespace and one sign are skipped; a base prefix is detected when
// cfg radix is 0 and a 0x prefix is skipped when it is 16.
// Output channel (out_valid/out_ready/out_data): at most one transaction per
// string, on the first byte that is not accepted, with the signed 64-bit value
// (wrapping) and the number of bytes consumed before it (saturating).
// Bytes after that are dropped until the next start request.
// Throughput: one byte per cycle while the output is not stalled; the back
// end's 64-bit multiply-add by the base updates the value once per byte.
// Path: the stopping byte passes the classify register, the two-entry queue
// and the result register before its result appears.
// Reset: radix returns to 10, the parse state and all queues are empty.
// Stall: while a result waits and out_ready is low, the result register holds,
// the back end stops, the queue fills and in_ready then drops; no byte is lost.
// cfg_wr_en writes radix in the same edge; write only while the block is idle.
module integer_text_parser
  import itp_pkg::*;
#(
  parameter int unsigned MAX_TEXT = DEFAULT_MAX_TEXT
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_t       out_data,
  input  logic       cfg_wr_en,
  input  logic [5:0] cfg_wr_data
);

  logic [5:0] radix_r, radix_nxt;
  logic       f_valid, f_ready;
  cls_t       f_data;
  logic       q_valid, q_ready;
  cls_t       q_data;

  assign radix_nxt = cfg_wr_en ? cfg_wr_data : radix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else begin
      radix_r <= radix_nxt;
    end
  end

  itp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cls_valid (f_valid),
    .cls_ready (f_ready),
    .cls_data  (f_data)
  );

  itp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_data),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_data)
  );

  itp_back #(
    .MAX_TEXT (MAX_TEXT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .radix     (radix_r),
    .cls_valid (q_valid),
    .cls_ready (q_ready),
    .cls_data  (q_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: sim/tb_top.sv
module tb_top;
  import itp_pkg::*;

  localparam int STALL_LIMIT = 2000;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = "+";
  localparam logic [7:0] CH_MINUS = "-";
  localparam logic [7:0] CH_ZERO  = "0";
  localparam logic [7:0] CH_NINE  = "9";
  localparam logic [7:0] CH_LA    = "a";
  localparam logic [7:0] CH_LZ    = "z";
  localparam logic [7:0] CH_UA    = "A";
  localparam logic [7:0] CH_UZ    = "Z";
  localparam logic [7:0] CH_LX    = "x";
  localparam logic [7:0] CH_UX    = "X";

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_t        in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_t       out_data;
  logic       cfg_wr_en = 1'b0;
  logic [5:0] cfg_wr_data = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int bytes_sent = 0;
  int mismatch_count = 0;
  int quiet_cycles = 0;
  bit string_open = 1'b0;

  // Parser state mirrored on the testbench side
  logic [5:0]  cur_radix;
  phase_t      parse_phase;
  logic [63:0] parse_acc;
  logic        parse_negative;
  logic [5:0]  parse_base;
  logic [11:0] parse_count;
  out_t        pending_results[$];

  integer_text_parser u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Parse prediction
  // ---------------------------------------------------------------------------
  function automatic logic [6:0] char_worth(logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return 7'(c - CH_ZERO);
    if (c >= CH_LA && c <= CH_LZ) return 7'(c - CH_LA + 8'd10);
    if (c >= CH_UA && c <= CH_UZ) return 7'(c - CH_UA + 8'd10);
    return WORTH_NONE;
  endfunction

  task automatic clear_parse();
    parse_phase = PH_SPACE;
    parse_acc = '0;
    parse_negative = 1'b0;
    parse_base = '0;
    parse_count = '0;
  endtask

  task automatic take_char();
    if (parse_count < COUNT_LIMIT) parse_count++;
  endtask

  task automatic digit_or_stop(input logic [7:0] c);
    logic [6:0] w;
    out_t       r;
    w = char_worth(c);
    if (w >= {1'b0, parse_base}) begin
      r.value = parse_negative ? -parse_acc : parse_acc;
      r.consumed = parse_count;
      pending_results.push_back(r);
      parse_phase = PH_DONE;
    end else begin
      parse_acc = parse_acc * parse_base + w;
      take_char();
      parse_phase = PH_DIGITS;
    end
  endtask

  // First byte past whitespace and sign: pick the base, maybe enter the prefix
  task automatic begin_number(input logic [7:0] c);
    if (cur_radix == RADIX_DETECT) begin
      if (c == CH_ZERO) begin
        parse_base = BASE_OCT;
        take_char();
        parse_phase = PH_ZERO;
        return;
      end
      parse_base = BASE_DEC;
    end else begin
      parse_base = cur_radix;
      if (cur_radix == BASE_HEX && c == CH_ZERO) begin
        take_char();
        parse_phase = PH_ZERO;
        return;
      end
    end
    digit_or_stop(c);
  endtask

  task automatic predict_byte(input in_t item);
    logic [7:0] c;
    c = item.character;
    if (item.start_req) clear_parse();
    case (parse_phase)
      PH_SPACE: begin
        if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
          take_char();
        end else if (c == CH_MINUS || c == CH_PLUS) begin
          if (c == CH_MINUS) parse_negative = 1'b1;
          take_char();
          parse_phase = PH_PREFIX;
        end else begin
          begin_number(c);
        end
      end
      PH_PREFIX: begin_number(c);
      PH_ZERO: begin
        if (c == CH_LX || c == CH_UX) begin
          parse_base = BASE_HEX;
          take_char();
          parse_phase = PH_DIGITS;
        end else begin
          digit_or_stop(c);
        end
      end
      PH_DIGITS: digit_or_stop(c);
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic start, input logic [7:0] c);
    in_t item;
    item.start_req = start;
    item.character = c;
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    predict_byte(item);
  endtask

  // Send one byte of the current string; the first one carries the start request
  task automatic emit(input logic [7:0] c);
    send_byte(!string_open, c);
    string_open = 1'b1;
  endtask

  task automatic emit_text(input string s);
    for (int i = 0; i < s.len(); i++) emit(s[i]);
  endtask

  task automatic parse_text(input string s, input logic [7:0] stop);
    string_open = 1'b0;
    emit_text(s);
    emit(stop);
  endtask

  // Wait out every pending result, then let trailing ignored bytes drain
  task automatic settle_parser();
    int saved_pct;
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    saved_pct = recv_idle_pct;
    recv_idle_pct = 0;
    repeat (16) @(posedge clk);
    recv_idle_pct = saved_pct;
  endtask

  task automatic write_radix(input logic [5:0] v);
    settle_parser();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cur_radix = v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_idle_pct);

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : check_results
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: value=%0d consumed=%0d",
                                  out_data.value, out_data.consumed));
      end else begin
        want = pending_results.pop_front();
        if (out_data.value !== want.value)
          report_mismatch($sformatf("value %0d, expected %0d", out_data.value, want.value));
        if (out_data.consumed !== want.consumed)
          report_mismatch($sformatf("consumed %0d, expected %0d",
                                    out_data.consumed, want.consumed));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_decimal();
    write_radix(BASE_DEC);
    parse_text("", CH_NUL);
    // every whitespace byte, then a signed number
    string_open = 1'b0;
    emit(CH_SPACE);
    for (int k = CH_TAB; k <= CH_CR; k++) emit(8'(k));
    emit_text("-123");
    emit(CH_NUL);
    parse_text("+9223372036854775807", CH_NUL);
    parse_text("18446744073709551617", CH_NUL);
    parse_text("-9223372036854775808", ".");
    // bytes after the stop are dropped until the next start
    parse_text("12", "a");
    emit("7");
    // a start request mid-string abandons the old parse
    string_open = 1'b0;
    emit_text("98");
    parse_text("34", CH_NUL);
    parse_text("-", "x");
    parse_text("5", 8'hFF);
  endtask

  task automatic test_base_detect();
    write_radix(RADIX_DETECT);
    parse_text("0x1fF", CH_NUL);
    parse_text("0X", "g");
    parse_text("017", CH_NUL);
    parse_text("0", "9");
    parse_text("  -42", CH_NUL);
    parse_text("-0x10", CH_NUL);
  endtask

  task automatic test_hex_prefix();
    write_radix(BASE_HEX);
    parse_text("0xDEADbeef", CH_NUL);
    parse_text("Ff", CH_NUL);
    parse_text("0x", CH_NUL);
    parse_text("0", "g");
  endtask

  task automatic test_odd_radix();
    write_radix(6'd1);
    parse_text("000", "1");
    write_radix(6'd2);
    parse_text("101", "2");
    write_radix(BASE_OCT);
    parse_text("77", "8");
    write_radix(6'd36);
    parse_text("zZ9", "!");
    write_radix(6'd37);
    parse_text("zz", "_");
    write_radix(6'd63);
    parse_text("Zz0", CH_NUL);
  endtask

  function automatic logic [5:0] pick_radix();
    logic [5:0] r;
    case ($urandom_range(7))
      0: r = RADIX_DETECT;
      1: r = BASE_HEX;
      2: r = BASE_DEC;
      3: r = 6'd1;
      4: r = 6'd36;
      5: r = 6'd63;
      6: r = 6'($urandom_range(2, 36));
      default: r = 6'($urandom_range(37, 63));
    endcase
    return r;
  endfunction

  function automatic logic [7:0] digit_char(input int w);
    if (w < 10) return 8'(CH_ZERO + w);
    return 8'(($urandom_range(1) ? CH_LA : CH_UA) + w - 10);
  endfunction

  // Mostly well-formed numbers with random content; some raw noise
  task automatic send_random_string();
    int n;
    int k;
    int gen_base;
    string_open = 1'b0;
    if ($urandom_range(9) == 0) begin
      n = $urandom_range(1, 8);
      repeat (n) begin
        send_byte(!string_open || ($urandom_range(7) == 0), 8'($urandom_range(255)));
        string_open = 1'b1;
      end
      return;
    end
    repeat ($urandom_range(0, 3)) begin
      k = $urandom_range(5);
      emit(k == 5 ? CH_SPACE : 8'(CH_TAB + k));
    end
    k = $urandom_range(3);
    if (k == 0) emit(CH_MINUS);
    else if (k == 1) emit(CH_PLUS);
    gen_base = (cur_radix > 36) ? 36 : cur_radix;
    if (cur_radix == RADIX_DETECT) begin
      gen_base = BASE_DEC;
      k = $urandom_range(2);
      if (k != 0) begin
        emit(CH_ZERO);
        gen_base = BASE_OCT;
      end
      if (k == 2) begin
        emit($urandom_range(1) ? CH_LX : CH_UX);
        gen_base = BASE_HEX;
      end
    end else if (cur_radix == BASE_HEX && $urandom_range(1)) begin
      emit(CH_ZERO);
      emit($urandom_range(1) ? CH_LX : CH_UX);
    end
    n = ($urandom_range(3) == 0) ? $urandom_range(0, 22) : $urandom_range(0, 6);
    repeat (n) emit(digit_char($urandom_range(0, gen_base - 1)));
    emit($urandom_range(1) ? CH_NUL : 8'($urandom_range(255)));
    if ($urandom_range(3) == 0)
      repeat ($urandom_range(1, 3)) send_byte(1'b0, 8'($urandom_range(255)));
  endtask

  task automatic test_random_text(input int send_pct, input int recv_pct, input int n_bytes);
    int target;
    int round_end;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      write_radix(pick_radix());
      round_end = bytes_sent + $urandom_range(30, 60);
      while (bytes_sent < round_end) send_random_string();
    end
  endtask

  initial begin
    cur_radix = RADIX_RESET;
    clear_parse();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 16;
    recv_idle_pct = 79;
    test_decimal();
    test_base_detect();
    test_hex_prefix();
    test_odd_radix();
    test_random_text(16, 79, 80);
    test_random_text(79, 16, 80);
    test_random_text(0, 0, 80);
    settle_parser();

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: sim.f
design/itp_pkg.sv
design/itp_front.sv
design/itp_queue.sv
design/itp_back.sv
design/integer_text_parser.sv
sim/tb_top.sv
